### rtl/spp_pkg.sv
`default_nettype none

package spp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_WIN_WIDTH  = 3'd2,
    REG_WIN_HEIGHT = 3'd3,
    REG_CENTER_X   = 3'd4,
    REG_CENTER_Y   = 3'd5,
    REG_CHANNELS   = 3'd6
  } cfg_reg_t;

  // kind of work held in the memory access stage
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ZERO  = 2'd2
  } op_t;

  // request kinds on the input word
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam int CFG_DW   = 18;
  localparam int CFG_IW   = 3;
  localparam int COORD_W  = 9;
  localparam int SUM_W    = 13;

  // clamp a signed source coordinate into [0, size-1]
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                     input logic [COORD_W-1:0] size);
    logic signed [SUM_W-1:0] lim;
    lim = $signed({{(SUM_W-COORD_W){1'b0}}, size});
    if (v < 0) begin
      clamp_coord = '0;
    end else if (v >= lim) begin
      clamp_coord = size - COORD_W'(1);
    end else begin
      clamp_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/spp_store.sv
`default_nettype none

module spp_store #(
  parameter int DEPTH = 196608,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/subpixel_patch_sampler.sv
`default_nettype none
// channel   direction  handshake                    word
// request   in         start && !busy               req_type col row chan pixel_in
// result    out        out_strobe, one cycle        pixel_out
// config    in         cfg_valid && cfg_ready       cfg_index cfg_data
//
// A write uses the image memory port once, so writes go at one a cycle while no
// read holds the port. A read uses the port four times: its four neighbours come
// one after another from the single-port image memory. A read of a channel that
// does not exist skips the memory and returns zero. Reset is synchronous and clears
// control and configuration; the image memory is not cleared and needs no pass.
// busy rises only while a request waits for the memory port; results cannot stall.

module subpixel_patch_sampler
  import spp_pkg::*;
#(
  parameter int MAX_WIDTH        = 256,
  parameter int MAX_HEIGHT       = 256,
  parameter int MAX_CHANNELS     = 3,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              req_type,
  input  wire logic [7:0]        col,
  input  wire logic [7:0]        row,
  input  wire logic [1:0]        chan,
  input  wire logic [7:0]        pixel_in,
  output logic                   out_strobe,
  output logic      [7:0]        pixel_out,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = WEIGHT_FRAC_BITS + 1;
  localparam int TW    = WEIGHT_FRAC_BITS + 19;
  localparam int PW    = WW + 8;
  localparam int SW    = WEIGHT_FRAC_BITS + 10;

  // round a product of two 9-bit axis weights to the weight precision
  function automatic logic [WW-1:0] round_weight(input logic [17:0] p);
    logic [TW-1:0] t;
    t = {1'b0, p, {WEIGHT_FRAC_BITS{1'b0}}} + TW'(32768);
    round_weight = t[16 +: WW];
  endfunction

  // configuration registers
  logic [8:0]               src_width, src_height, win_width, win_height;
  logic signed [CFG_DW-1:0] center_x, center_y;
  logic [1:0]               channels;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 9'd256;
      src_height <= 9'd256;
      win_width  <= 9'd16;
      win_height <= 9'd16;
      center_x   <= '0;
      center_y   <= '0;
      channels   <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data[8:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[8:0];
        REG_WIN_WIDTH:  win_width  <= cfg_data[8:0];
        REG_WIN_HEIGHT: win_height <= cfg_data[8:0];
        REG_CENTER_X:   center_x   <= $signed(cfg_data);
        REG_CENTER_Y:   center_y   <= $signed(cfg_data);
        REG_CHANNELS:   channels   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // request stage
  logic       s1_vld, s1_type;
  logic [7:0] s1_col, s1_row, s1_pix;
  logic [1:0] s1_chan;

  // memory access stage
  logic               s2_vld;
  op_t                s2_op;
  logic [1:0]         s2_k;
  logic [COORD_W-1:0] s2_x0, s2_x1, s2_y0, s2_y1;
  logic [1:0]         s2_chan;
  logic [7:0]         s2_wdata;
  logic [WW-1:0]      s2_w00, s2_w10, s2_w01, s2_w11;

  logic s2_done, s2_free, s1_adv, accept;

  assign s2_done = s2_vld && ((s2_op != OP_READ) || (s2_k == 2'd3));
  assign s2_free = !s2_vld || s2_done;
  assign s1_adv  = s1_vld && s2_free;
  assign busy    = s1_vld && !s2_free;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (accept) begin
      s1_vld <= 1'b1;
    end else if (s1_adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type <= req_type;
      s1_col  <= col;
      s1_row  <= row;
      s1_chan <= chan;
      s1_pix  <= pixel_in;
    end
  end

  // effective sizes and channel check
  logic [8:0] w_eff, h_eff, ww_eff, wh_eff, wwm1, whm1;
  logic [1:0] nch;
  logic       chan_ok, wr_in_store;

  always_comb begin
    if (src_width == 9'd0) begin
      w_eff = 9'd1;
    end else if ({4'b0, src_width} > 13'(MAX_WIDTH)) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = src_width;
    end
    if (src_height == 9'd0) begin
      h_eff = 9'd1;
    end else if ({4'b0, src_height} > 13'(MAX_HEIGHT)) begin
      h_eff = 9'(MAX_HEIGHT);
    end else begin
      h_eff = src_height;
    end
  end

  assign ww_eff      = (win_width == 9'd0) ? 9'd1 : win_width;
  assign wh_eff      = (win_height == 9'd0) ? 9'd1 : win_height;
  assign wwm1        = ww_eff - 9'd1;
  assign whm1        = wh_eff - 9'd1;
  assign nch         = (channels == 2'd0) ? 2'd1 : channels;
  assign chan_ok     = (s1_chan < nch) && ({2'b0, s1_chan} < 4'(MAX_CHANNELS));
  assign wr_in_store = ({5'b0, s1_col} < 13'(MAX_WIDTH)) &&
                       ({5'b0, s1_row} < 13'(MAX_HEIGHT));

  // window origin: integer part by floor, 8 fraction bits
  logic signed [18:0] org_x, org_y;
  logic signed [10:0] ip_x, ip_y;
  logic [7:0]         fx, fy;

  assign org_x = {center_x[CFG_DW-1], center_x} - $signed({3'b0, wwm1, 7'b0});
  assign org_y = {center_y[CFG_DW-1], center_y} - $signed({3'b0, whm1, 7'b0});
  assign ip_x  = org_x[18:8];
  assign ip_y  = org_y[18:8];
  assign fx    = org_x[7:0];
  assign fy    = org_y[7:0];

  // neighbour coordinates
  logic signed [SUM_W-1:0] sx0, sx1, sy0, sy1;

  assign sx0 = {{(SUM_W-11){ip_x[10]}}, ip_x} + $signed({5'b0, s1_col});
  assign sx1 = sx0 + SUM_W'(1);
  assign sy0 = {{(SUM_W-11){ip_y[10]}}, ip_y} + $signed({5'b0, s1_row});
  assign sy1 = sy0 + SUM_W'(1);

  // bilinear weights
  logic [8:0]  ax, ay, bx, by;
  logic [17:0] p00, p10, p01, p11;

  assign ax  = 9'd256 - {1'b0, fx};
  assign ay  = 9'd256 - {1'b0, fy};
  assign bx  = {1'b0, fx};
  assign by  = {1'b0, fy};
  assign p00 = ax * ay;
  assign p10 = bx * ay;
  assign p01 = ax * by;
  assign p11 = bx * by;

  // hand the request to the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
      s2_k   <= 2'd0;
    end else if (s1_adv) begin
      s2_vld <= (s1_type == REQ_READ) || (chan_ok && wr_in_store);
      s2_k   <= 2'd0;
    end else if (s2_done) begin
      s2_vld <= 1'b0;
    end else if (s2_vld) begin
      s2_k   <= s2_k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_chan  <= s1_chan;
      s2_wdata <= s1_pix;
      s2_w00   <= round_weight(p00);
      s2_w10   <= round_weight(p10);
      s2_w01   <= round_weight(p01);
      s2_w11   <= round_weight(p11);
      if (s1_type == REQ_WRITE) begin
        s2_op <= OP_WRITE;
        s2_x0 <= {1'b0, s1_col};
        s2_y0 <= {1'b0, s1_row};
        s2_x1 <= {1'b0, s1_col};
        s2_y1 <= {1'b0, s1_row};
      end else begin
        s2_op <= chan_ok ? OP_READ : OP_ZERO;
        s2_x0 <= clamp_coord(sx0, w_eff);
        s2_x1 <= clamp_coord(sx1, w_eff);
        s2_y0 <= clamp_coord(sy0, h_eff);
        s2_y1 <= clamp_coord(sy1, h_eff);
      end
    end
  end

  // neighbour select and address
  logic [COORD_W-1:0] sel_x, sel_y;
  logic [WW-1:0]      sel_w;
  logic [AW-1:0]      mem_addr;
  logic               mem_en, mem_we;
  logic [7:0]         mem_rdata;

  always_comb begin
    unique case (s2_k)
      2'd0: begin sel_x = s2_x0; sel_y = s2_y0; sel_w = s2_w00; end
      2'd1: begin sel_x = s2_x1; sel_y = s2_y0; sel_w = s2_w10; end
      2'd2: begin sel_x = s2_x0; sel_y = s2_y1; sel_w = s2_w01; end
      default: begin sel_x = s2_x1; sel_y = s2_y1; sel_w = s2_w11; end
    endcase
  end

  assign mem_addr = AW'((32'(sel_y) * MAX_WIDTH + 32'(sel_x)) * MAX_CHANNELS + 32'(s2_chan));
  assign mem_en   = s2_vld && (s2_op != OP_ZERO);
  assign mem_we   = s2_op == OP_WRITE;

  spp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (s2_wdata),
    .rdata (mem_rdata)
  );

  // read data tag, lines up with the registered memory output
  logic          rd_vld, rd_first, rd_last, rd_zero;
  logic [WW-1:0] rd_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= s2_vld && (s2_op != OP_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= (s2_k == 2'd0);
    rd_last  <= s2_done;
    rd_zero  <= s2_op == OP_ZERO;
    rd_w     <= sel_w;
  end

  // weighted product
  logic          pr_vld, pr_first, pr_last, pr_zero;
  logic [PW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_vld <= 1'b0;
    end else begin
      pr_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    pr_first <= rd_first;
    pr_last  <= rd_last;
    pr_zero  <= rd_zero;
    prod     <= mem_rdata * rd_w;
  end

  // accumulate, round half up, saturate; a bad-channel read gives zero
  logic [SW-1:0] acc, acc_sum, rnd;
  logic [9:0]    q;

  assign acc_sum = (pr_first ? '0 : acc) + SW'(prod);
  assign rnd     = acc_sum + SW'(1 << (WEIGHT_FRAC_BITS - 1));
  assign q       = rnd[SW-1:WEIGHT_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (pr_vld) begin
      acc <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= pr_vld && pr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_vld && pr_last) begin
      if (pr_zero) begin
        pixel_out <= 8'd0;
      end else if (q > 10'd255) begin
        pixel_out <= 8'd255;
      end else begin
        pixel_out <= q[7:0];
      end
    end
  end

endmodule

`default_nettype wire

### test/subpixel_patch_sampler_tb.sv
`timescale 1ns / 1ps

module subpixel_patch_sampler_tb;
  import spp_pkg::*;

  localparam int IMG_W          = 256;
  localparam int IMG_H          = 256;
  localparam int IMG_CH         = 3;
  localparam int WEIGHT_BITS    = 16;
  localparam int STORE_DEPTH    = IMG_W * IMG_H * IMG_CH;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 64;
  localparam int PHASES         = 10;
  localparam int MAX_REPORTS    = 10;
  localparam logic [CFG_IW-1:0] CFG_SPARE = 3'd7;

  typedef struct {
    logic       req_type;
    logic [7:0] col;
    logic [7:0] row;
    logic [1:0] chan;
    logic [7:0] pixel;
  } request_t;

  typedef struct {
    int unsigned src_w;
    int unsigned src_h;
    int unsigned win_w;
    int unsigned win_h;
    int          ctr_x;
    int          ctr_y;
    int unsigned nch;
  } setting_t;

  // shadow of the image store and register file, predicts each interpolated byte
  class sampler_scoreboard;
    logic [8:0]   src_w, src_h, win_w, win_h;
    int           ctr_x, ctr_y;
    logic [1:0]   nch_reg;
    byte unsigned image [STORE_DEPTH];
    bit           written [STORE_DEPTH];
    logic [7:0]   expected_pixels [$];
    int unsigned  fails;

    function new();
      src_w   = 9'd256;
      src_h   = 9'd256;
      win_w   = 9'd16;
      win_h   = 9'd16;
      ctr_x   = 0;
      ctr_y   = 0;
      nch_reg = 2'd1;
      fails   = 0;
    endfunction

    function void set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  src_w = data[8:0];
        REG_SRC_HEIGHT: src_h = data[8:0];
        REG_WIN_WIDTH:  win_w = data[8:0];
        REG_WIN_HEIGHT: win_h = data[8:0];
        REG_CENTER_X:   ctr_x = $signed(data);
        REG_CENTER_Y:   ctr_y = $signed(data);
        REG_CHANNELS:   nch_reg = data[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_src(input int unsigned v, input int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function int unsigned chans();
      return (nch_reg == 0) ? 1 : nch_reg;
    endfunction

    function bit chan_ok(input logic [1:0] ch);
      return (ch < chans()) && (ch < IMG_CH);
    endfunction

    function int unsigned store_at(input int unsigned x, y, input logic [1:0] ch);
      return (y * IMG_W + x) * IMG_CH + ch;
    endfunction

    // window origin along one axis, floor integer part and 8-bit fraction
    function void axis_origin(input int ctr, input int unsigned win,
                              output int ip, output int unsigned fr);
      int v;
      v  = ctr - int'((win - 1) * 128);
      ip = v >>> 8;
      fr = v & 255;
    endfunction

    function int unsigned clamp_axis(input int v, input int unsigned size);
      if (v < 0) return 0;
      if (v >= int'(size)) return size - 1;
      return v;
    endfunction

    // four neighbour coordinates and fractions for a patch position
    function void locate(input logic [7:0] c, r,
                         output int unsigned x0, x1, y0, y1, fx, fy);
      int ipx, ipy;
      int unsigned w, h;
      w = eff_src(src_w, IMG_W);
      h = eff_src(src_h, IMG_H);
      axis_origin(ctr_x, (win_w == 0) ? 1 : win_w, ipx, fx);
      axis_origin(ctr_y, (win_h == 0) ? 1 : win_h, ipy, fy);
      x0 = clamp_axis(ipx + int'(c), w);
      x1 = clamp_axis(ipx + int'(c) + 1, w);
      y0 = clamp_axis(ipy + int'(r), h);
      y1 = clamp_axis(ipy + int'(r) + 1, h);
    endfunction

    function longint unsigned weight(input int unsigned p);
      longint unsigned w;
      w = p;
      return ((w << WEIGHT_BITS) + 64'd32768) >> 16;
    endfunction

    function logic [7:0] interpolate(input logic [7:0] c, r, input logic [1:0] ch);
      int unsigned x0, x1, y0, y1, fx, fy;
      longint unsigned acc;
      locate(c, r, x0, x1, y0, y1, fx, fy);
      acc = image[store_at(x0, y0, ch)] * weight((256 - fx) * (256 - fy))
          + image[store_at(x1, y0, ch)] * weight(fx * (256 - fy))
          + image[store_at(x0, y1, ch)] * weight((256 - fx) * fy)
          + image[store_at(x1, y1, ch)] * weight(fx * fy);
      acc = (acc + (64'd1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
      return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    // first neighbour of a read that was never written, if any
    function bit missing_neighbour(input logic [7:0] c, r, input logic [1:0] ch,
                                   output logic [7:0] mx, my);
      int unsigned x0, x1, y0, y1, fx, fy;
      mx = '0;
      my = '0;
      if (!chan_ok(ch)) return 0;
      locate(c, r, x0, x1, y0, y1, fx, fy);
      if (!written[store_at(x0, y0, ch)]) begin
        mx = 8'(x0); my = 8'(y0); return 1;
      end
      if (!written[store_at(x1, y0, ch)]) begin
        mx = 8'(x1); my = 8'(y0); return 1;
      end
      if (!written[store_at(x0, y1, ch)]) begin
        mx = 8'(x0); my = 8'(y1); return 1;
      end
      if (!written[store_at(x1, y1, ch)]) begin
        mx = 8'(x1); my = 8'(y1); return 1;
      end
      return 0;
    endfunction

    function void note_request(input request_t q);
      if (q.req_type == REQ_WRITE) begin
        if (chan_ok(q.chan)) begin
          image[store_at(q.col, q.row, q.chan)]   = q.pixel;
          written[store_at(q.col, q.row, q.chan)] = 1'b1;
        end
      end else begin
        expected_pixels.push_back(chan_ok(q.chan) ? interpolate(q.col, q.row, q.chan) : 8'd0);
      end
    endfunction

    function void check_pixel(input logic [7:0] got);
      logic [7:0] want;
      if (expected_pixels.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS) $display("unexpected pixel_out %0d", got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= MAX_REPORTS) $display("pixel_out mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic                 req_type  = REQ_WRITE;
  logic [7:0]           col       = '0;
  logic [7:0]           row       = '0;
  logic [1:0]           chan      = '0;
  logic [7:0]           pixel_in  = '0;
  logic                 out_strobe;
  logic [7:0]           pixel_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IW-1:0]    cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data  = '0;

  sampler_scoreboard sb = new();
  int unsigned       sent = 0;
  int unsigned       quiet_cycles = 0;

  subpixel_patch_sampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .col       (col),
    .row       (row),
    .chan      (chan),
    .pixel_in  (pixel_in),
    .out_strobe(out_strobe),
    .pixel_out (pixel_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result words, checked in order of arrival
  always @(posedge clk) begin
    if (!rst && out_strobe === 1'b1) sb.check_pixel(pixel_out);
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic request_t make_req(input logic rt, input logic [7:0] c, r,
                                        input logic [1:0] ch, input logic [7:0] p);
    request_t q;
    q.req_type = rt;
    q.col      = c;
    q.row      = r;
    q.chan     = ch;
    q.pixel    = p;
    return q;
  endfunction

  // mostly reads of filled neighbourhoods, writes that fill them, some noise
  function automatic request_t pick_request();
    request_t    q;
    int unsigned w, h, nch, span_x, span_y, kind;
    logic [7:0]  mx, my;
    w      = sb.eff_src(sb.src_w, IMG_W);
    h      = sb.eff_src(sb.src_h, IMG_H);
    nch    = sb.chans();
    span_x = (sb.win_w == 0) ? 1 : ((sb.win_w > IMG_W) ? IMG_W : sb.win_w);
    span_y = (sb.win_h == 0) ? 1 : ((sb.win_h > IMG_H) ? IMG_H : sb.win_h);
    kind   = $urandom_range(99);
    q.pixel = 8'($urandom);
    q.chan  = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(nch - 1));
    if (kind < 35) begin
      q.req_type = REQ_WRITE;
      q.col      = 8'($urandom_range(w - 1));
      q.row      = 8'($urandom_range(h - 1));
    end else if (kind < 45) begin
      q.req_type = REQ_WRITE;
      q.col      = 8'($urandom);
      q.row      = 8'($urandom);
      q.chan     = 2'($urandom);
    end else begin
      q.req_type = REQ_READ;
      q.col = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(span_x - 1));
      q.row = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(span_y - 1));
      // a read over unwritten pixels turns into a write that fills one of them
      if (sb.missing_neighbour(q.col, q.row, q.chan, mx, my)) begin
        q.req_type = REQ_WRITE;
        q.col      = mx;
        q.row      = my;
      end
    end
    return q;
  endfunction

  // one request word, with sender gaps in front of it
  task automatic send_request(input request_t q);
    int unsigned pct;
    pct = (sent < 218) ? 29 : ((sent < 436) ? 88 : 0);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= q.req_type;
    col      <= q.col;
    row      <= q.row;
    chan     <= q.chan;
    pixel_in <= q.pixel;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(q);
    sent++;
  endtask

  // drain all results, then let trailing writes leave the pipeline
  task automatic finish_phase();
    start <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // every register plus the spare index, unused upper bits randomised
  task automatic load_config(input setting_t s);
    logic [CFG_DW-1:0] word [8];
    word[REG_SRC_WIDTH]  = {9'($urandom), 9'(s.src_w)};
    word[REG_SRC_HEIGHT] = {9'($urandom), 9'(s.src_h)};
    word[REG_WIN_WIDTH]  = {9'($urandom), 9'(s.win_w)};
    word[REG_WIN_HEIGHT] = {9'($urandom), 9'(s.win_h)};
    word[REG_CENTER_X]   = CFG_DW'(s.ctr_x);
    word[REG_CENTER_Y]   = CFG_DW'(s.ctr_y);
    word[REG_CHANNELS]   = {16'($urandom), 2'(s.nch)};
    word[CFG_SPARE]      = CFG_DW'($urandom);
    for (int i = 0; i < $size(word); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_data  <= word[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      sb.set_reg(CFG_IW'(i), word[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    setting_t plan [PHASES];
    plan[0] = '{4, 4, 4, 4, 'h240, 'h1C0, 3};
    plan[1] = '{1, 1, 1, 1, 0, 0, 1};
    plan[2] = '{0, 0, 0, 0, -300, 77, 0};
    plan[3] = '{256, 1, 256, 2, 'h8000, 0, 2};
    plan[4] = '{5, 3, 256, 256, 131071, -131072, 3};
    plan[5] = '{511, 2, 7, 3, -131072, 131071, 1};
    plan[6] = '{2, 300, 9, 200, 'h3FF, -77, 2};
    for (int p = 7; p < PHASES; p++) begin
      plan[p].src_w = $urandom_range(9);
      plan[p].src_h = $urandom_range(9);
      plan[p].win_w = $urandom_range(300);
      plan[p].win_h = $urandom_range(300);
      plan[p].ctr_x = ($urandom_range(3) == 0) ? $signed(18'($urandom))
                                               : int'($urandom_range(4095)) - 2048;
      plan[p].ctr_y = ($urandom_range(3) == 0) ? $signed(18'($urandom))
                                               : int'($urandom_range(4095)) - 2048;
      plan[p].nch   = $urandom_range(3);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings: corners of the byte range, bad channels,
    // clamping at the left and top edges, positions past the window
    send_request(make_req(REQ_WRITE, 0, 0, 0, 255));
    send_request(make_req(REQ_WRITE, 1, 0, 0, 0));
    send_request(make_req(REQ_WRITE, 0, 1, 0, 128));
    send_request(make_req(REQ_WRITE, 1, 1, 0, 1));
    send_request(make_req(REQ_WRITE, 0, 0, 3, 7));
    send_request(make_req(REQ_WRITE, 0, 0, 1, 9));
    send_request(make_req(REQ_WRITE, 255, 255, 0, 170));
    send_request(make_req(REQ_WRITE, 255, 255, 2, 85));
    send_request(make_req(REQ_READ, 0, 0, 0, 255));
    send_request(make_req(REQ_READ, 8, 8, 0, 0));
    send_request(make_req(REQ_READ, 7, 8, 0, 0));
    send_request(make_req(REQ_READ, 8, 8, 3, 0));
    send_request(make_req(REQ_READ, 255, 255, 1, 255));
    send_request(make_req(REQ_READ, 3, 2, 0, 0));
    finish_phase();

    // random phases over a spread of register settings
    for (int p = 0; p < PHASES; p++) begin
      load_config(plan[p]);
      repeat (PHASE_ITEMS) send_request(pick_request());
      finish_phase();
    end

    if (sb.fails == 0 && sb.expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
